// ===== hdl/lpp_pkg.sv =====
package lpp_pkg;

    localparam int THR_W      = 12;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int WSUM_W     = 7;
    localparam int FRAC_W     = 8;
    localparam int DIV_W      = WSUM_W - 1 + FRAC_W;
    localparam int DIVCNT_W   = $clog2(DIV_W);
    localparam int ERR_W      = 14;
    localparam int INTEG_W    = 16;
    localparam int INTS_W     = INTEG_W + 1;
    localparam int DERIV_W    = 15;
    localparam int MULB_W     = INTS_W;
    localparam int PROD_W     = GAIN_W + 1 + MULB_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int GAIN_FRAC  = 12;
    localparam int DRIVE_W    = 24;
    localparam int COUNT_W    = 4;

    localparam int DRIVE_MAX   = 8388607;
    localparam int DRIVE_MIN   = -8388608;
    localparam int SIX_ON_LINE = 6;
    localparam int ERR_MAX     = 6912;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;

    localparam logic [THR_W-1:0]   RST_THRESHOLD   = 12'd500;
    localparam logic [GAIN_W-1:0]  RST_GAIN_PROP   = 20'd172032;
    localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG  = 20'd16;
    localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV  = 20'd532480;
    localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 15'd25600;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SCAN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ERR,
        OP_INTEG,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_MUL_ACC,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_SCAN_MORE,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic scan_last;
        logic div_last;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integ;
        logic [GAIN_W-1:0]  gain_deriv;
        logic [LIMIT_W-1:0] integ_limit;
    } t_cfg;

    localparam t_step STEP_LOAD     = 4'd0;
    localparam t_step STEP_SCAN     = 4'd1;
    localparam t_step STEP_DIV_INIT = 4'd2;
    localparam t_step STEP_DIV      = 4'd3;
    localparam t_step STEP_ERR      = 4'd4;
    localparam t_step STEP_INTEG    = 4'd5;
    localparam t_step STEP_MUL_P    = 4'd6;
    localparam t_step STEP_MUL_I    = 4'd7;
    localparam t_step STEP_MUL_D    = 4'd8;
    localparam t_step STEP_MUL_ACC  = 4'd9;
    localparam t_step STEP_OUT      = 4'd10;
    localparam t_step STEP_DONE     = 4'd11;

    function automatic t_uop ucode(input t_step step);
        t_uop w;
        unique case (step)
            STEP_LOAD:     w = '{OP_LOAD,     COND_NO_IN,     STEP_LOAD};
            STEP_SCAN:     w = '{OP_SCAN,     COND_SCAN_MORE, STEP_SCAN};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER,     STEP_LOAD};
            STEP_DIV:      w = '{OP_DIV_STEP, COND_DIV_MORE,  STEP_DIV};
            STEP_ERR:      w = '{OP_ERR,      COND_NEVER,     STEP_LOAD};
            STEP_INTEG:    w = '{OP_INTEG,    COND_NEVER,     STEP_LOAD};
            STEP_MUL_P:    w = '{OP_MUL_P,    COND_NEVER,     STEP_LOAD};
            STEP_MUL_I:    w = '{OP_MUL_I,    COND_NEVER,     STEP_LOAD};
            STEP_MUL_D:    w = '{OP_MUL_D,    COND_NEVER,     STEP_LOAD};
            STEP_MUL_ACC:  w = '{OP_MUL_ACC,  COND_NEVER,     STEP_LOAD};
            STEP_OUT:      w = '{OP_OUT,      COND_OUT_BUSY,  STEP_OUT};
            STEP_DONE:     w = '{OP_NOP,      COND_ALWAYS,    STEP_LOAD};
            default:       w = '{OP_NOP,      COND_ALWAYS,    STEP_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic signed [WSUM_W-1:0] weight(input logic [3:0] idx);
        logic signed [WSUM_W-1:0] w;
        case (idx)
            4'd0:    w = WSUM_W'(27);
            4'd1:    w = WSUM_W'(17);
            4'd2:    w = WSUM_W'(10);
            4'd3:    w = WSUM_W'(6);
            4'd4:    w = WSUM_W'(-6);
            4'd5:    w = WSUM_W'(-10);
            4'd6:    w = WSUM_W'(-17);
            4'd7:    w = WSUM_W'(-27);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/lpp_in_if.sv =====
interface lpp_in_if #(
    parameter int NUM_SENSORS = 8,
    parameter int SAMPLE_BITS = 12
) ();
    logic                                    valid;
    logic                                    ready;
    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== hdl/lpp_out_if.sv =====
interface lpp_out_if import lpp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   line_error;
    logic [COUNT_W-1:0]        on_line_count;

    modport source (output valid, output drive, output line_error, output on_line_count,
                    input ready);
    modport sink (input valid, input drive, input line_error, input on_line_count,
                  output ready);
endinterface

// ===== hdl/lpp_seq.sv =====
module lpp_seq import lpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uop    o_uop
);

    t_step r_step;
    t_step n_step;
    t_uop  uop;
    logic  taken;

    always_comb begin
        uop = ucode(r_step);
        case (uop.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NO_IN:     taken = !i_status.in_valid;
            COND_SCAN_MORE: taken = !i_status.scan_last;
            COND_DIV_MORE:  taken = !i_status.div_last;
            COND_OUT_BUSY:  taken = i_status.out_busy;
            default:        taken = 1'b1;
        endcase
        n_step = taken ? uop.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uop = uop;

endmodule

// ===== hdl/lpp_datapath.sv =====
module lpp_datapath import lpp_pkg::*; #(
    parameter int NUM_SENSORS = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_uop      i_uop,
    input  t_cfg      i_cfg,
    output t_status   o_status,
    lpp_in_if.sink    i_line,
    lpp_out_if.source o_pid
);

    localparam int IDX_W = $clog2(NUM_SENSORS);
    localparam int CNT_W = $clog2(NUM_SENSORS + 1);
    localparam int REM_W = CNT_W + 1;
    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(DRIVE_MAX);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(DRIVE_MIN);

    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] r_samples;
    logic [IDX_W-1:0]                        r_idx;
    logic [CNT_W-1:0]                        r_count;
    logic signed [WSUM_W-1:0]                r_wsum;
    logic                                    r_neg;
    logic [DIV_W-1:0]                        r_quo;
    logic [REM_W-1:0]                        r_rem;
    logic [DIVCNT_W-1:0]                     r_divcnt;
    logic signed [ERR_W-1:0]                 r_err;
    logic signed [INTEG_W-1:0]               r_integ_sum;
    logic signed [ERR_W-1:0]                 r_prev_err;
    logic signed [DERIV_W-1:0]               r_deriv;
    logic signed [PROD_W-1:0]                r_prod;
    logic signed [ACC_W-1:0]                 r_acc;
    logic                                    r_out_valid;
    logic signed [DRIVE_W-1:0]               r_drive;
    logic signed [ERR_W-1:0]                 r_line_err;
    logic [COUNT_W-1:0]                      r_on_count;

    logic                      in_xfer;
    logic                      out_busy;
    logic                      hit;
    logic [WSUM_W-1:0]         wsum_mag;
    logic [REM_W-1:0]          trial;
    logic                      trial_ge;
    logic                      err_zero;
    logic signed [INTS_W-1:0]  integ_add;
    logic signed [INTS_W-1:0]  lim_pos;
    logic signed [INTS_W-1:0]  lim_neg;
    logic signed [INTEG_W-1:0] integ_next;
    logic [GAIN_W-1:0]         mult_a;
    logic signed [MULB_W-1:0]  mult_b;
    logic signed [PROD_W-1:0]  mult_p;
    logic signed [ACC_W-1:0]   acc_shr;
    logic signed [DRIVE_W-1:0] drive_sat;

    assign in_xfer  = i_line.valid && i_line.ready;
    assign out_busy = r_out_valid && !o_pid.ready;

    assign i_line.ready = (i_uop.op == OP_LOAD);

    assign o_status.in_valid  = i_line.valid;
    assign o_status.scan_last = (r_idx == IDX_W'(NUM_SENSORS - 1));
    assign o_status.div_last  = (r_divcnt == DIVCNT_W'(DIV_W - 1));
    assign o_status.out_busy  = out_busy;

    assign hit = CMP_W'(r_samples[r_idx]) <= CMP_W'(i_cfg.threshold);

    assign wsum_mag = r_wsum[WSUM_W-1] ? WSUM_W'(-r_wsum) : WSUM_W'(r_wsum);
    assign trial    = {r_rem[CNT_W-1:0], r_quo[DIV_W-1]};
    assign trial_ge = trial >= REM_W'(r_count);
    assign err_zero = (r_count == '0) || (int'(r_count) == SIX_ON_LINE);

    assign integ_add = INTS_W'(r_integ_sum) + INTS_W'(r_err);
    assign lim_pos   = $signed(INTS_W'(i_cfg.integ_limit));
    assign lim_neg   = -lim_pos;

    always_comb begin
        if (integ_add > lim_pos) begin
            integ_next = INTEG_W'(lim_pos);
        end else if (integ_add < lim_neg) begin
            integ_next = INTEG_W'(lim_neg);
        end else begin
            integ_next = INTEG_W'(integ_add);
        end
    end

    always_comb begin
        case (i_uop.op)
            OP_MUL_P: begin
                mult_a = i_cfg.gain_prop;
                mult_b = MULB_W'(r_err);
            end
            OP_MUL_I: begin
                mult_a = i_cfg.gain_integ;
                mult_b = MULB_W'(r_integ_sum);
            end
            OP_MUL_D: begin
                mult_a = i_cfg.gain_deriv;
                mult_b = MULB_W'(r_deriv);
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign mult_p = $signed({1'b0, mult_a}) * mult_b;

    assign acc_shr = r_acc >>> GAIN_FRAC;

    always_comb begin
        if (acc_shr > ACC_HI) begin
            drive_sat = DRIVE_W'(ACC_HI);
        end else if (acc_shr < ACC_LO) begin
            drive_sat = DRIVE_W'(ACC_LO);
        end else begin
            drive_sat = DRIVE_W'(acc_shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_sum <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_uop.op == OP_INTEG) begin
                r_integ_sum <= integ_next;
                r_prev_err  <= r_err;
            end
            if (i_uop.op == OP_OUT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_pid.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_uop.op)
            OP_LOAD: begin
                if (in_xfer) begin
                    r_samples <= i_line.sample;
                    r_idx     <= '0;
                    r_count   <= '0;
                    r_wsum    <= '0;
                end
            end
            OP_SCAN: begin
                r_idx <= r_idx + 1'b1;
                if (hit) begin
                    r_count <= r_count + 1'b1;
                    r_wsum  <= r_wsum + weight(4'(r_idx));
                end
            end
            OP_DIV_INIT: begin
                r_neg    <= r_wsum[WSUM_W-1];
                r_quo    <= {wsum_mag[WSUM_W-2:0], FRAC_W'(0)};
                r_rem    <= '0;
                r_divcnt <= '0;
            end
            OP_DIV_STEP: begin
                r_divcnt <= r_divcnt + 1'b1;
                r_quo    <= {r_quo[DIV_W-2:0], trial_ge};
                r_rem    <= trial_ge ? trial - REM_W'(r_count) : trial;
            end
            OP_ERR: begin
                if (err_zero) begin
                    r_err <= '0;
                end else begin
                    r_err <= r_neg ? -$signed(r_quo) : $signed(r_quo);
                end
            end
            OP_INTEG: begin
                r_deriv <= DERIV_W'(r_err) - DERIV_W'(r_prev_err);
            end
            OP_MUL_P: begin
                r_prod <= mult_p;
            end
            OP_MUL_I: begin
                r_prod <= mult_p;
                r_acc  <= ACC_W'(r_prod);
            end
            OP_MUL_D: begin
                r_prod <= mult_p;
                r_acc  <= r_acc + ACC_W'(r_prod);
            end
            OP_MUL_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_OUT: begin
                if (!out_busy) begin
                    r_drive    <= drive_sat;
                    r_line_err <= r_err;
                    r_on_count <= COUNT_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pid.valid         = r_out_valid;
    assign o_pid.drive         = r_drive;
    assign o_pid.line_error    = r_line_err;
    assign o_pid.on_line_count = r_on_count;

`ifndef SYNTHESIS
    a_out_after_out_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_uop.op == OP_OUT))
        else $error("result raised outside the output step");

    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_uop.op == OP_INTEG) |->
            (INTS_W'(r_integ_sum) <= $signed(INTS_W'($past(i_cfg.integ_limit))) &&
             INTS_W'(r_integ_sum) >= -$signed(INTS_W'($past(i_cfg.integ_limit)))))
        else $error("integral outside its limit");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_uop.op == OP_ERR) |-> (int'(r_err) <= ERR_MAX && int'(r_err) >= -ERR_MAX))
        else $error("line error out of range");
`endif

endmodule

// ===== hdl/line_position_pid_unit.sv =====
// channel   dir  payload                                  transfer when
// i_line    in   sample[NUM_SENSORS] x SAMPLE_BITS        valid && ready
// o_pid     out  drive, line_error, on_line_count         valid && ready
// cfg       in   i_cfg_idx, i_cfg_data                    i_cfg_we
//
// one item runs through these steps in order: load, one scan step per sensor, divider
// setup plus 14 restoring steps, error, integral, three products and an add on the one
// shared multiplier, the result step and a closing step
// reset clears step counter, integral, previous error, output valid; config to defaults
// a stalled output holds the sequencer at its result step; the next input is taken while
// a finished result still waits
module line_position_pid_unit import lpp_pkg::*; #(
    parameter int NUM_SENSORS = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpp_in_if.sink                i_line,
    lpp_out_if.source             o_pid
);

    t_cfg    r_cfg;
    t_uop    uop;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= RST_THRESHOLD;
            r_cfg.gain_prop   <= RST_GAIN_PROP;
            r_cfg.gain_integ  <= RST_GAIN_INTEG;
            r_cfg.gain_deriv  <= RST_GAIN_DERIV;
            r_cfg.integ_limit <= RST_INTEG_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD:   r_cfg.threshold   <= i_cfg_data[THR_W-1:0];
                REG_GAIN_PROP:   r_cfg.gain_prop   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG:  r_cfg.gain_integ  <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV:  r_cfg.gain_deriv  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lpp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uop    (uop)
    );

    lpp_datapath #(
        .NUM_SENSORS (NUM_SENSORS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uop    (uop),
        .i_cfg    (r_cfg),
        .o_status (status),
        .i_line   (i_line),
        .o_pid    (o_pid)
    );

endmodule
